// ===== rtl/tts_pkg.sv =====
package tts_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CODE,
    S_OPER
  } state_t;

  // Input item commands.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Tune byte codes; 0 to 11 are notes.
  localparam logic [7:0] NOTES_PER_OCTAVE = 8'd12;
  localparam logic [7:0] CODE_REPEAT      = 8'd12;
  localparam logic [7:0] CODE_OCTAVE      = 8'd13;
  localparam logic [7:0] CODE_REST        = 8'd14;
  localparam logic [7:0] CODE_END         = 8'd15;

  localparam logic [2:0] ROM_OCTAVES = 3'd7;
  localparam logic [2:0] OCTAVE_MAX  = 3'd7;

  // Timer divisor per note: 1193280 / frequency, rounded down. Zero marks the
  // missing last note of the top octave.
  function automatic logic [15:0] note_divisor(input logic [6:0] idx);
    logic [15:0] d;
    case (idx)
      7'd0:  d = 16'd9122;  7'd1:  d = 16'd8612;  7'd2:  d = 16'd8126;
      7'd3:  d = 16'd7670;  7'd4:  d = 16'd7240;  7'd5:  d = 16'd6833;
      7'd6:  d = 16'd6450;  7'd7:  d = 16'd6088;  7'd8:  d = 16'd5746;
      7'd9:  d = 16'd5424;  7'd10: d = 16'd5249;  7'd11: d = 16'd4831;
      7'd12: d = 16'd4560;  7'd13: d = 16'd4305;  7'd14: d = 16'd4063;
      7'd15: d = 16'd3835;  7'd16: d = 16'd3620;  7'd17: d = 16'd3416;
      7'd18: d = 16'd3225;  7'd19: d = 16'd3044;  7'd20: d = 16'd2873;
      7'd21: d = 16'd2712;  7'd22: d = 16'd2624;  7'd23: d = 16'd2415;
      7'd24: d = 16'd2280;  7'd25: d = 16'd2152;  7'd26: d = 16'd2031;
      7'd27: d = 16'd1917;  7'd28: d = 16'd1810;  7'd29: d = 16'd1708;
      7'd30: d = 16'd1612;  7'd31: d = 16'd1522;  7'd32: d = 16'd1436;
      7'd33: d = 16'd1356;  7'd34: d = 16'd1312;  7'd35: d = 16'd1207;
      7'd36: d = 16'd1140;  7'd37: d = 16'd1076;  7'd38: d = 16'd1015;
      7'd39: d = 16'd958;   7'd40: d = 16'd898;   7'd41: d = 16'd854;
      7'd42: d = 16'd806;   7'd43: d = 16'd761;   7'd44: d = 16'd718;
      7'd45: d = 16'd678;   7'd46: d = 16'd656;   7'd47: d = 16'd603;
      7'd48: d = 16'd570;   7'd49: d = 16'd538;   7'd50: d = 16'd507;
      7'd51: d = 16'd479;   7'd52: d = 16'd452;   7'd53: d = 16'd427;
      7'd54: d = 16'd403;   7'd55: d = 16'd380;   7'd56: d = 16'd359;
      7'd57: d = 16'd339;   7'd58: d = 16'd328;   7'd59: d = 16'd301;
      7'd60: d = 16'd285;   7'd61: d = 16'd269;   7'd62: d = 16'd253;
      7'd63: d = 16'd239;   7'd64: d = 16'd226;   7'd65: d = 16'd213;
      7'd66: d = 16'd201;   7'd67: d = 16'd190;   7'd68: d = 16'd179;
      7'd69: d = 16'd169;   7'd70: d = 16'd164;   7'd71: d = 16'd150;
      7'd72: d = 16'd142;   7'd73: d = 16'd134;   7'd74: d = 16'd126;
      7'd75: d = 16'd119;   7'd76: d = 16'd113;   7'd77: d = 16'd106;
      7'd78: d = 16'd95;    7'd79: d = 16'd89;    7'd80: d = 16'd84;
      7'd81: d = 16'd82;    7'd82: d = 16'd75;
      default: d = 16'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/tts_ram.sv =====
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tone_tune_sequencer.sv =====
// Channel   Ports                              Handshake
// -------   --------------------------------   ------------------------------
// input     in_cmd, in_address, in_data        start high while busy low
// result    out_speaker_on, out_tone_divisor,  out_valid high for one cycle
//           out_finished, out_fault
// config    cfg_wdata                          cfg_we high
//
// A load, restart, idle tick or counting tick is handled in the idle state;
// its result beat appears the cycle after it is accepted. A tick that
// runs tune commands (up to MAX_CMDS_PER_TICK of them) stays busy while
// each command needs one read of the tune RAM for its code and, for all but
// repeat and end, one more for its operand. Reset clears all control state;
// the tune RAM keeps no reset value. The receiver cannot stall result beats.
module tone_tune_sequencer #(
  parameter int TUNE_DEPTH        = 256,
  parameter int OCTAVES           = 7,
  parameter int MAX_CMDS_PER_TICK = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_speaker_on,
  output logic [15:0] out_tone_divisor,
  output logic        out_finished,
  output logic        out_fault
);

  localparam int AW = $clog2(TUNE_DEPTH);
  localparam int MW = AW + 4;
  localparam int CW = $clog2(MAX_CMDS_PER_TICK);

  // An 8-bit address modulo the tune depth; the depth is at least 16, so the
  // quotient needs no more than four bits.
  function automatic logic [AW-1:0] wrap_addr(input logic [7:0] a);
    logic [MW-1:0] v;
    v = MW'(a);
    for (int k = 3; k >= 0; k--) begin
      if (v >= (MW'(TUNE_DEPTH) << k)) begin
        v = v - (MW'(TUNE_DEPTH) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  tts_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [AW-1:0]   start_ptr_r;
  logic [7:0]      time_r, time_nxt;
  logic [2:0]      oct_r, oct_nxt;
  logic [15:0]     div_r, div_nxt;
  logic            sound_r, sound_nxt;
  logic            stop_r, stop_nxt;
  logic            fault_r, fault_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [7:0]      code_r, code_nxt;
  logic            valid_r, valid_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_q;
  logic [AW-1:0]   ptr_inc;
  logic            cap_hit;
  logic [6:0]      rom_idx;
  logic [15:0]     rom_div;
  logic            note_ok;
  logic [7:0]      len;

  tts_ram #(
    .WIDTH(8),
    .DEPTH(TUNE_DEPTH)
  ) u_tune_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wrap_addr(in_address)),
    .wdata(in_data),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign ptr_inc = (ptr_r == AW'(TUNE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign cap_hit = (cnt_r == CW'(MAX_CMDS_PER_TICK - 1));
  assign rom_idx = 7'(oct_r) * 7'd12 + 7'(code_r[3:0]);
  assign rom_div = tts_pkg::note_divisor(rom_idx);
  assign note_ok = (code_r < tts_pkg::NOTES_PER_OCTAVE) &&
                   ({1'b0, oct_r} < 4'(OCTAVES)) &&
                   (oct_r < tts_pkg::ROM_OCTAVES) &&
                   (rom_div != 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tts_pkg::S_IDLE;
      ptr_r       <= '0;
      start_ptr_r <= '0;
      time_r      <= '0;
      oct_r       <= '0;
      div_r       <= '0;
      sound_r     <= 1'b0;
      stop_r      <= 1'b0;
      fault_r     <= 1'b0;
      cnt_r       <= '0;
      valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      time_r  <= time_nxt;
      oct_r   <= oct_nxt;
      div_r   <= div_nxt;
      sound_r <= sound_nxt;
      stop_r  <= stop_nxt;
      fault_r <= fault_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        start_ptr_r <= wrap_addr(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    time_nxt  = time_r;
    oct_nxt   = oct_r;
    div_nxt   = div_r;
    sound_nxt = sound_r;
    stop_nxt  = stop_r;
    fault_nxt = fault_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    valid_nxt = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = ptr_r;
    len       = 8'd0;
    unique case (state_r)
      tts_pkg::S_IDLE: begin
        if (start) begin
          fault_nxt = 1'b0;
          cnt_nxt   = '0;
          unique case (in_cmd)
            tts_pkg::CMD_LOAD: begin
              ram_we    = 1'b1;
              valid_nxt = 1'b1;
            end
            tts_pkg::CMD_TICK: begin
              if (stop_r) begin
                valid_nxt = 1'b1;
              end else if (time_r != 8'd0) begin
                time_nxt  = time_r - 8'd1;
                valid_nxt = 1'b1;
              end else begin
                // The code at the pointer is being read now.
                state_nxt = tts_pkg::S_CODE;
              end
            end
            tts_pkg::CMD_RESTART: begin
              ptr_nxt   = start_ptr_r;
              time_nxt  = 8'd0;
              sound_nxt = 1'b0;
              stop_nxt  = 1'b0;
              valid_nxt = 1'b1;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      tts_pkg::S_CODE: begin
        case (ram_q)
          tts_pkg::CODE_REPEAT: begin
            ptr_nxt   = start_ptr_r;
            ram_raddr = start_ptr_r;
            if (cap_hit) begin
              fault_nxt = 1'b1;
              valid_nxt = 1'b1;
              state_nxt = tts_pkg::S_IDLE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          tts_pkg::CODE_END: begin
            sound_nxt = 1'b0;
            stop_nxt  = 1'b1;
            valid_nxt = 1'b1;
            state_nxt = tts_pkg::S_IDLE;
          end
          default: begin
            code_nxt  = ram_q;
            ptr_nxt   = ptr_inc;
            ram_raddr = ptr_inc;
            state_nxt = tts_pkg::S_OPER;
          end
        endcase
      end
      tts_pkg::S_OPER: begin
        ptr_nxt = ptr_inc;
        case (code_r)
          tts_pkg::CODE_OCTAVE: begin
            oct_nxt = (ram_q > 8'(tts_pkg::OCTAVE_MAX)) ? tts_pkg::OCTAVE_MAX : ram_q[2:0];
          end
          tts_pkg::CODE_REST: begin
            len       = ram_q;
            sound_nxt = 1'b0;
          end
          default: begin
            // A bad note still takes its length but silences the speaker.
            len = ram_q;
            if (note_ok) begin
              div_nxt   = rom_div;
              sound_nxt = 1'b1;
            end else begin
              sound_nxt = 1'b0;
              fault_nxt = 1'b1;
            end
          end
        endcase
        if (len != 8'd0) begin
          // This tick counts as the first tick of the note or rest.
          time_nxt  = len - 8'd1;
          valid_nxt = 1'b1;
          state_nxt = tts_pkg::S_IDLE;
        end else if (cap_hit) begin
          time_nxt  = 8'd0;
          fault_nxt = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = tts_pkg::S_IDLE;
        end else begin
          time_nxt  = 8'd0;
          cnt_nxt   = cnt_r + 1'b1;
          ram_raddr = ptr_inc;
          state_nxt = tts_pkg::S_CODE;
        end
      end
      default: begin
        state_nxt = tts_pkg::S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != tts_pkg::S_IDLE);
  assign out_valid        = valid_r;
  assign out_speaker_on   = sound_r;
  assign out_tone_divisor = div_r;
  assign out_finished     = stop_r;
  assign out_fault        = fault_r;

`ifndef SYNTHESIS
  a_beat_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == tts_pkg::S_IDLE))
    else $error("result beat while a tick is still running");

  a_counting_tick_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == tts_pkg::CMD_TICK && !stop_r && time_r != 8'd0)
    |=> valid_r)
    else $error("counting tick did not report in the next cycle");

  a_oper_after_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tts_pkg::S_OPER) |-> ($past(state_r) == tts_pkg::S_CODE))
    else $error("operand read without a code read before it");

  a_sound_has_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    sound_r |-> (div_r != 16'd0))
    else $error("speaker on with a zero divisor");
`endif

endmodule

// ===== test/tts_checker.sv =====
`timescale 1ns / 100ps
module tts_checker #(
  parameter int OCTAVE_COUNT = 7,
  parameter int CMD_CAP      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        out_valid,
  input  logic        out_speaker_on,
  input  logic [15:0] out_tone_divisor,
  input  logic        out_finished,
  input  logic        out_fault,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic        speaker_on;
    logic [15:0] tone_divisor;
    logic        finished;
    logic        fault;
  } player_status_t;

  // Timer divisors per octave and note; the last entry of the top octave is absent.
  localparam logic [15:0] NOTE_DIVISORS [0:83] = '{
    16'd9122, 16'd8612, 16'd8126, 16'd7670, 16'd7240, 16'd6833,
    16'd6450, 16'd6088, 16'd5746, 16'd5424, 16'd5249, 16'd4831,
    16'd4560, 16'd4305, 16'd4063, 16'd3835, 16'd3620, 16'd3416,
    16'd3225, 16'd3044, 16'd2873, 16'd2712, 16'd2624, 16'd2415,
    16'd2280, 16'd2152, 16'd2031, 16'd1917, 16'd1810, 16'd1708,
    16'd1612, 16'd1522, 16'd1436, 16'd1356, 16'd1312, 16'd1207,
    16'd1140, 16'd1076, 16'd1015, 16'd958,  16'd898,  16'd854,
    16'd806,  16'd761,  16'd718,  16'd678,  16'd656,  16'd603,
    16'd570,  16'd538,  16'd507,  16'd479,  16'd452,  16'd427,
    16'd403,  16'd380,  16'd359,  16'd339,  16'd328,  16'd301,
    16'd285,  16'd269,  16'd253,  16'd239,  16'd226,  16'd213,
    16'd201,  16'd190,  16'd179,  16'd169,  16'd164,  16'd150,
    16'd142,  16'd134,  16'd126,  16'd119,  16'd113,  16'd106,
    16'd95,   16'd89,   16'd84,   16'd82,   16'd75,   16'd0
  };

  logic [7:0]  tune_bytes [0:255];
  logic [7:0]  play_ptr;
  logic [7:0]  ticks_left;
  logic [2:0]  octave;
  logic [15:0] divisor;
  logic        gate_on;
  logic        halted;
  logic [7:0]  start_addr;

  player_status_t expected_q [$];
  int             result_beats;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t MISMATCH %s: got %0d, expected %0d (result beat %0d)",
             $time, what, got, want, result_beats);
    mismatches = mismatches + 1;
  endtask

  // Runs tune commands until one sets a nonzero length, the tune ends or the
  // per-tick cap runs out.
  task automatic play_commands(output logic hit_fault);
    int          n;
    logic [6:0]  idx;
    logic [7:0]  code;
    logic [7:0]  arg;
    logic [15:0] div;
    logic        settled;
    hit_fault = 1'b0;
    settled   = 1'b0;
    for (n = 0; n < CMD_CAP && !settled; n++) begin
      code = tune_bytes[play_ptr];
      case (code)
        tts_pkg::CODE_REPEAT: begin
          play_ptr = start_addr;
        end
        tts_pkg::CODE_OCTAVE: begin
          play_ptr = play_ptr + 8'd1;
          arg      = tune_bytes[play_ptr];
          octave   = (arg > 8'd7) ? tts_pkg::OCTAVE_MAX : arg[2:0];
          play_ptr = play_ptr + 8'd1;
        end
        tts_pkg::CODE_REST: begin
          play_ptr   = play_ptr + 8'd1;
          ticks_left = tune_bytes[play_ptr];
          gate_on    = 1'b0;
          play_ptr   = play_ptr + 8'd1;
        end
        tts_pkg::CODE_END: begin
          gate_on = 1'b0;
          halted  = 1'b1;
          settled = 1'b1;
        end
        default: begin
          play_ptr   = play_ptr + 8'd1;
          ticks_left = tune_bytes[play_ptr];
          div        = 16'd0;
          if (code < tts_pkg::NOTES_PER_OCTAVE && int'(octave) < OCTAVE_COUNT &&
              octave < tts_pkg::ROM_OCTAVES) begin
            idx = 7'(octave) * 7'(tts_pkg::NOTES_PER_OCTAVE) + 7'(code[3:0]);
            div = NOTE_DIVISORS[idx];
          end
          if (div != 16'd0) begin
            divisor = div;
            gate_on = 1'b1;
          end else begin
            gate_on   = 1'b0;
            hit_fault = 1'b1;
          end
          play_ptr = play_ptr + 8'd1;
        end
      endcase
      // The tick that starts a note also counts as its first tick.
      if (!settled && ticks_left != 8'd0) begin
        ticks_left = ticks_left - 8'd1;
        settled    = 1'b1;
      end
    end
    if (!settled) hit_fault = 1'b1;
  endtask

  task automatic predict_status(input logic [1:0] cmd, input logic [7:0] addr,
                                input logic [7:0] data, output player_status_t st);
    logic flt;
    flt = 1'b0;
    case (cmd)
      tts_pkg::CMD_LOAD: begin
        tune_bytes[addr] = data;
      end
      tts_pkg::CMD_TICK: begin
        if (!halted) begin
          if (ticks_left != 8'd0) ticks_left = ticks_left - 8'd1;
          else play_commands(flt);
        end
      end
      tts_pkg::CMD_RESTART: begin
        play_ptr   = start_addr;
        ticks_left = 8'd0;
        gate_on    = 1'b0;
        halted     = 1'b0;
      end
      default: ;
    endcase
    st.speaker_on   = gate_on;
    st.tone_divisor = divisor;
    st.finished     = halted;
    st.fault        = flt;
  endtask

  always @(posedge clk) begin
    player_status_t got_st;
    player_status_t want_st;
    if (!rst_n) begin
      play_ptr     = 8'd0;
      ticks_left   = 8'd0;
      octave       = 3'd0;
      divisor      = 16'd0;
      gate_on      = 1'b0;
      halted       = 1'b0;
      start_addr   = 8'd0;
      result_beats = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) start_addr = cfg_wdata;
      if (out_valid) begin
        result_beats = result_beats + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", 16'd0, 16'd0);
        end else begin
          want_st = expected_q.pop_front();
          got_st  = {out_speaker_on, out_tone_divisor, out_finished, out_fault};
          if (got_st.speaker_on !== want_st.speaker_on)
            report_mismatch("speaker_on", 16'(got_st.speaker_on),
                            16'(want_st.speaker_on));
          if (got_st.tone_divisor !== want_st.tone_divisor)
            report_mismatch("tone_divisor", got_st.tone_divisor, want_st.tone_divisor);
          if (got_st.finished !== want_st.finished)
            report_mismatch("finished", 16'(got_st.finished), 16'(want_st.finished));
          if (got_st.fault !== want_st.fault)
            report_mismatch("fault", 16'(got_st.fault), 16'(want_st.fault));
        end
      end
      if (start && !busy) begin
        predict_status(in_cmd, in_address, in_data, want_st);
        expected_q.push_back(want_st);
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== test/tb_tone_tune_sequencer.sv =====
`timescale 1ns / 100ps
module tb_tone_tune_sequencer;

  // The block only clears its fault flag and returns a result beat for this command code.
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam int RANDOM_BEATS = 1150;
  localparam int MAX_GAP      = 18;
  localparam int DRAIN_CYCLES = 24;

  // Demo tune: missing top-octave note, a normal note, saturated octave with a
  // bad note, a zero-length note, a bad code, a zero-length rest, a note, then the end.
  localparam logic [7:0] DEMO_TUNE [0:20] = '{
    tts_pkg::CODE_OCTAVE, 8'd6, 8'd11, 8'd1, 8'd0, 8'd2,
    tts_pkg::CODE_OCTAVE, 8'd200, 8'd3, 8'd1,
    tts_pkg::CODE_OCTAVE, 8'd0, 8'd0, 8'd0,
    8'd255, 8'd1,
    tts_pkg::CODE_REST, 8'd0,
    8'd11, 8'd2,
    tts_pkg::CODE_END
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        start      = 1'b0;
  logic [1:0]  in_cmd     = tts_pkg::CMD_LOAD;
  logic [7:0]  in_address = 8'd0;
  logic [7:0]  in_data    = 8'd0;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = 8'd0;
  logic        busy;
  logic        out_valid;
  logic        out_speaker_on;
  logic [15:0] out_tone_divisor;
  logic        out_finished;
  logic        out_fault;

  int   mismatch_count;
  int   pending_beats;
  int   beats_sent   = 0;
  int   ticks_sent   = 0;
  int   random_beats = 0;
  int   phase_count  = 0;
  bit   no_gaps      = 1'b0;
  logic play_stopped = 1'b0;

  always #5 clk = ~clk;

  tone_tune_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_address       (in_address),
    .in_data          (in_data),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_speaker_on   (out_speaker_on),
    .out_tone_divisor (out_tone_divisor),
    .out_finished     (out_finished),
    .out_fault        (out_fault)
  );

  tts_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_address       (in_address),
    .in_data          (in_data),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_speaker_on   (out_speaker_on),
    .out_tone_divisor (out_tone_divisor),
    .out_finished     (out_finished),
    .out_fault        (out_fault),
    .mismatches       (mismatch_count),
    .outstanding      (pending_beats)
  );

  always @(posedge clk) begin
    if (out_valid) play_stopped <= out_finished;
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] addr,
                           input logic [7:0] data);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_address <= addr;
    in_data    <= data;
    do @(posedge clk); while (busy);
    beats_sent = beats_sent + 1;
    if (cmd == tts_pkg::CMD_TICK) ticks_sent = ticks_sent + 1;
  endtask

  task automatic put_byte(inout logic [7:0] addr, input logic [7:0] value);
    send_beat(tts_pkg::CMD_LOAD, addr, value);
    addr = addr + 8'd1;
    random_beats = random_beats + 1;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0 || busy) @(posedge clk);
  endtask

  task automatic write_start_address(input logic [7:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r < 5) return 8'd0;
    return 8'($urandom_range(1, 4));
  endfunction

  // Writes a tune at base: random bytes when garbage is set, else mostly well-formed commands with random operands.
  task automatic write_tune(input logic [7:0] base, input bit garbage);
    logic [7:0] addr;
    int         n;
    int         i;
    int         r;
    addr = base;
    if (garbage) begin
      n = $urandom_range(4, 24);
      for (i = 0; i < n; i++) put_byte(addr, 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(3, 12);
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          put_byte(addr, 8'($urandom_range(0, 11)));
          put_byte(addr, pick_length());
        end else if (r < 62) begin
          put_byte(addr, tts_pkg::CODE_OCTAVE);
          r = $urandom_range(0, 9);
          if (r == 0) put_byte(addr, 8'd7);
          else if (r == 1) put_byte(addr, 8'($urandom_range(8, 255)));
          else put_byte(addr, 8'($urandom_range(0, 6)));
        end else if (r < 76) begin
          put_byte(addr, tts_pkg::CODE_REST);
          put_byte(addr, pick_length());
        end else if (r < 84) begin
          put_byte(addr, 8'($urandom_range(16, 255)));
          put_byte(addr, pick_length());
        end else if (r < 88) begin
          put_byte(addr, tts_pkg::CODE_REPEAT);
        end else begin
          put_byte(addr, 8'($urandom_range(0, 11)));
          put_byte(addr, 8'($urandom_range(1, 2)));
        end
      end
      put_byte(addr, $urandom_range(0, 1) ? tts_pkg::CODE_END : tts_pkg::CODE_REPEAT);
    end
  endtask

  task automatic play_phase();
    int nticks;
    int t;
    int r;
    send_beat(tts_pkg::CMD_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_beats = random_beats + 1;
    nticks = $urandom_range(30, 90);
    for (t = 0; t < nticks; t++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_beat(tts_pkg::CMD_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (r < 6) begin
        send_beat(tts_pkg::CMD_RESTART, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else if (r < 8) begin
        send_beat(CMD_NOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        if (play_stopped && $urandom_range(0, 3) == 0) break;
        send_beat(tts_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      if (!play_stopped) random_beats = random_beats + 1;
    end
  endtask

  initial begin
    int         a;
    logic [7:0] sa;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Every tune entry gets written once, so play never reads an unwritten one.
    no_gaps = 1'b1;
    for (a = 0; a < 256; a++) send_beat(tts_pkg::CMD_LOAD, 8'(a), tts_pkg::CODE_END);
    no_gaps = 1'b0;

    write_start_address(8'd0);
    for (a = 0; a < 21; a++) send_beat(tts_pkg::CMD_LOAD, 8'(a), DEMO_TUNE[a]);
    // The ninth tick lands after the end command and must change nothing.
    repeat (9) send_beat(tts_pkg::CMD_TICK, 8'd0, 8'd0);
    send_beat(CMD_NOP, 8'hFF, 8'hFF);
    send_beat(tts_pkg::CMD_RESTART, 8'd0, 8'd0);
    send_beat(tts_pkg::CMD_TICK, 8'd0, 8'd0);

    // A lone repeat at the start address loops until the command cap trips.
    write_start_address(8'd21);
    send_beat(tts_pkg::CMD_LOAD, 8'd21, tts_pkg::CODE_REPEAT);
    send_beat(tts_pkg::CMD_RESTART, 8'd0, 8'd0);
    repeat (2) send_beat(tts_pkg::CMD_TICK, 8'd0, 8'd0);

    while (random_beats < RANDOM_BEATS) begin
      case (phase_count % 4)
        0:       sa = 8'd0;
        1:       sa = 8'd255;
        default: sa = 8'($urandom_range(0, 255));
      endcase
      phase_count = phase_count + 1;
      write_start_address(sa);
      no_gaps = ($urandom_range(0, 3) == 0);
      write_tune(sa, $urandom_range(0, 5) == 0);
      play_phase();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d beats sent, %0d of them ticks, over %0d tune phases", beats_sent,
             ticks_sent, phase_count);
    $display("Start addresses 0, 255 and random values were used; %0d mismatches counted",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: the run did not drain in time");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
